// ===== hw/rtl/bpp_pkg.sv =====
// Shared types and constants for the bounded-part partition counter.
`timescale 1ns / 1ps

package bpp_pkg;

   localparam int MAX_TOTAL_DEF = 8192;
   localparam int MAX_PART_DEF  = 4;
   localparam int TOTAL_IN_W    = 13;
   localparam int PART_IN_W     = 3;
   localparam int COUNT_W       = 33;

   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_WRITE,
      ST_LOOKUP,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;      // capture a new transaction
      logic fill_rd;   // read the operand for the current table entry
      logic fill_wr;   // write the current table entry and advance
      logic look_rd;   // read the answer entry
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic need_fill;  // query row lies beyond the filled rows
      logic last_entry; // current entry is the last one of the fill
   } status_type;

endpackage

// ===== hw/rtl/bpp_ctrl.sv =====
// Controller state machine: sequences table fill, lookup and response.
`timescale 1ns / 1ps

module bpp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  bpp_pkg::status_type status,
   output bpp_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);

   bpp_pkg::state_type state_ff;
   bpp_pkg::state_type state_in;

   // Hold the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decode next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      busy        = 1'b1;
      rsp_valid   = 1'b0;
      case (state_ff)
         bpp_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = bpp_pkg::ST_CHECK;
            end
         end
         bpp_pkg::ST_CHECK: begin
            if (status.need_fill) begin
               state_in = bpp_pkg::ST_READ;
            end else begin
               state_in = bpp_pkg::ST_LOOKUP;
            end
         end
         bpp_pkg::ST_READ: begin
            cmd.fill_rd = 1'b1;
            state_in    = bpp_pkg::ST_WRITE;
         end
         bpp_pkg::ST_WRITE: begin
            cmd.fill_wr = 1'b1;
            if (status.last_entry) begin
               state_in = bpp_pkg::ST_LOOKUP;
            end else begin
               state_in = bpp_pkg::ST_READ;
            end
         end
         bpp_pkg::ST_LOOKUP: begin
            cmd.look_rd = 1'b1;
            state_in    = bpp_pkg::ST_RESP;
         end
         bpp_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = bpp_pkg::ST_IDLE;
         end
         default: begin
            state_in = bpp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/bpp_datapath.sv =====
// Datapath: count table memory, fill counters and saturating accumulator.
`timescale 1ns / 1ps

module bpp_datapath #(
   parameter int MaxTotal = bpp_pkg::MAX_TOTAL_DEF,
   parameter int MaxPart  = bpp_pkg::MAX_PART_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bpp_pkg::cmd_type                  cmd,
   input  logic [bpp_pkg::TOTAL_IN_W-1:0]    req_total,
   input  logic [bpp_pkg::PART_IN_W-1:0]     req_max_part,
   output bpp_pkg::status_type               status,
   output bpp_pkg::count_type                rsp_partition_count
);

   localparam int TotalW = $clog2(MaxTotal);
   localparam int PartW  = $clog2(MaxPart + 1);
   localparam int AddrW  = TotalW + PartW;
   localparam int Depth  = 2 ** AddrW;

   bpp_pkg::count_type mem [Depth];

   logic [TotalW-1:0]  n_ff;
   logic [PartW-1:0]   k_ff;
   logic [TotalW-1:0]  m_ff;
   logic [PartW-1:0]   j_ff;
   logic [TotalW:0]    filled_ff;
   bpp_pkg::count_type acc_ff;
   bpp_pkg::count_type rd_data_ff;

   logic [TotalW-1:0]  n_in;
   logic [PartW-1:0]   k_in;
   logic [AddrW-1:0]   rd_addr;
   logic [TotalW-1:0]  j_wide;
   logic               row_end;
   logic [bpp_pkg::COUNT_W:0] sum;
   bpp_pkg::count_type entry_val;

   // Saturate the query fields to the table bounds
   always_comb begin
      if (32'(req_total) > 32'(MaxTotal - 1)) begin
         n_in = TotalW'(MaxTotal - 1);
      end else begin
         n_in = TotalW'(req_total);
      end
      if (32'(req_max_part) > 32'(MaxPart)) begin
         k_in = PartW'(MaxPart);
      end else begin
         k_in = PartW'(req_max_part);
      end
   end

   assign j_wide  = TotalW'(j_ff);
   assign row_end = (j_ff == PartW'(MaxPart));

   // Entry value: count(m, j) = count(m, j-1) + count(m-j, j)
   always_comb begin
      sum = {1'b0, acc_ff} + {1'b0, rd_data_ff};
      if (m_ff == '0) begin
         entry_val = bpp_pkg::count_type'(1);
      end else if (j_ff == '0) begin
         entry_val = '0;
      end else if (j_wide > m_ff) begin
         entry_val = acc_ff;
      end else if (sum[bpp_pkg::COUNT_W]) begin
         entry_val = '1;
      end else begin
         entry_val = sum[bpp_pkg::COUNT_W-1:0];
      end
   end

   // Select the read address: fill operand or final answer
   always_comb begin
      if (cmd.look_rd) begin
         rd_addr = {n_ff, k_ff};
      end else begin
         rd_addr = {m_ff - j_wide, j_ff};
      end
   end

   assign status.need_fill  = (filled_ff <= {1'b0, n_ff});
   assign status.last_entry = row_end && (m_ff == n_ff);
   assign rsp_partition_count = rd_data_ff;

   // Table memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (cmd.fill_wr) begin
         mem[{m_ff, j_ff}] <= entry_val;
      end
      if (cmd.fill_rd || cmd.look_rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Advance fill counters and track filled rows
   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
      end else if (cmd.fill_wr && row_end) begin
         filled_ff <= {1'b0, m_ff} + (TotalW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff   <= n_in;
         k_ff   <= k_in;
         m_ff   <= filled_ff[TotalW-1:0];
         j_ff   <= '0;
         acc_ff <= '0;
      end else if (cmd.fill_wr) begin
         if (row_end) begin
            j_ff   <= '0;
            m_ff   <= m_ff + TotalW'(1);
            acc_ff <= '0;
         end else begin
            j_ff   <= j_ff + PartW'(1);
            acc_ff <= entry_val;
         end
      end
   end

endmodule

// ===== hw/rtl/bounded_part_partition_counter.sv =====
// Top level of the bounded-part partition counter.
//
// Usage: drive req_total and req_max_part and raise start; the query is taken
// at a rising edge where start is high and busy is low. One result follows on
// rsp_partition_count, marked by rsp_valid for exactly one cycle; the
// receiver must take it in that cycle. A total above MaxTotal-1 and a part
// limit above MaxPart are saturated; counts saturate at 2^33-1.
// A count table holds every row (all part limits 0..MaxPart) for the
// totals filled so far. A query whose total is already covered passes
// through the check and lookup states to the response strobe. Otherwise
// the missing rows are filled first, each entry by a table read and then the
// write that depends on it. One transaction is in flight at a time; busy
// stays high until the response and drops the cycle after it, so a new
// query is taken only after the previous response has been given.
// Reset clears the filled-row count, so the table is rebuilt on demand; no
// clearing pass is run over the memory.
`timescale 1ns / 1ps

module bounded_part_partition_counter #(
   parameter int MaxTotal = bpp_pkg::MAX_TOTAL_DEF,
   parameter int MaxPart  = bpp_pkg::MAX_PART_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [bpp_pkg::TOTAL_IN_W-1:0]    req_total,
   input  logic [bpp_pkg::PART_IN_W-1:0]     req_max_part,
   output logic                              rsp_valid,
   output logic [bpp_pkg::COUNT_W-1:0]       rsp_partition_count
);

   bpp_pkg::cmd_type    cmd;
   bpp_pkg::status_type status;

   bpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   bpp_datapath #(
      .MaxTotal (MaxTotal),
      .MaxPart  (MaxPart)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_total           (req_total),
      .req_max_part        (req_max_part),
      .status              (status),
      .rsp_partition_count (rsp_partition_count)
   );

endmodule
